/* rtl/core/met_pkg.sv */
package met_pkg;

	localparam int unsigned MET_QDEPTH = 4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_F      = 8'h46;
	localparam logic [7:0] CH_LBR    = 8'h5B;
	localparam logic [7:0] CH_RBR    = 8'h5D;

	localparam logic [4:0] ARG_NONE     = 5'h1F;
	localparam logic [4:0] KIND_FONT    = 5'd5;
	localparam logic [4:0] KIND_ICON    = 5'd13;
	localparam logic [4:0] KIND_TEXTW   = 5'd14;
	localparam logic [4:0] KIND_UNKNOWN = 5'd15;
	localparam logic [4:0] KIND_PERCENT = 5'd16;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_DOL   = 4'd1,
		PH_DOLD  = 4'd2,
		PH_PCT   = 4'd3,
		PH_PCTD  = 4'd4,
		PH_WSEL  = 4'd5,
		PH_WBR   = 4'd6,
		PH_LABEL = 4'd7,
		PH_FONTF = 4'd8
	} phase_t;

	typedef enum logic [2:0] {
		REC_TEXT    = 3'd0,
		REC_TOKEN   = 3'd1,
		REC_HEADER  = 3'd2,
		REC_LABEL   = 3'd3,
		REC_CLOSE   = 3'd4,
		REC_MISSING = 3'd5,
		REC_END     = 3'd6
	} rec_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_UNKNOWN = 2'd1,
		ERR_BRACKET = 2'd2
	} err_t;

	typedef struct packed {
		rec_t       rec_type;
		logic [4:0] kind;
		logic [4:0] arg;
		logic [7:0] letter;
		logic [7:0] data_byte;
		err_t       error_code;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} step_out_t;

	typedef struct packed {
		logic room;
		logic full;
	} q_stat_t;

	function automatic res_t mk_rec(rec_t t, logic [4:0] k, logic [4:0] a,
			logic [7:0] l, logic [7:0] d, err_t e);
		res_t r;
		r.rec_type   = t;
		r.kind       = k;
		r.arg        = a;
		r.letter     = l;
		r.data_byte  = d;
		r.error_code = e;
		r.last       = 1'b0;
		return r;
	endfunction

	// Dollar letter table: < = A B C F L M R T Y [ ] i t
	function automatic logic [4:0] classify(logic [7:0] c);
		logic [4:0] k;
		unique case (c)
			8'h3C: k = 5'd0;
			8'h3D: k = 5'd1;
			8'h41: k = 5'd2;
			8'h42: k = 5'd3;
			8'h43: k = 5'd4;
			8'h46: k = 5'd5;
			8'h4C: k = 5'd6;
			8'h4D: k = 5'd7;
			8'h52: k = 5'd8;
			8'h54: k = 5'd9;
			8'h59: k = 5'd10;
			8'h5B: k = 5'd11;
			8'h5D: k = 5'd12;
			8'h69: k = 5'd13;
			8'h74: k = 5'd14;
			default: k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic is_selector(logic [7:0] c);
		return c == 8'h61 || c == 8'h6E || c == 8'h69 || c == 8'h62 ||
			c == 8'h63 || c == 8'h73 || c == 8'h74;
	endfunction

endpackage

/* rtl/core/met_step.sv */
module met_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            code,
	output met_pkg::step_out_t    step
);

	typedef struct packed {
		met_pkg::phase_t phase;
		logic [4:0]      arg;
		logic [4:0]      kind;
		logic [7:0]      letter;
		met_pkg::err_t   err;
	} st_t;

	typedef struct packed {
		logic          emit;
		met_pkg::res_t rec;
	} opt_rec_t;

	st_t st_q;
	st_t st_nx;

	logic       is_nul;
	logic       is_digit;
	logic [4:0] kind_c;
	logic       sel_c;
	opt_rec_t   idle_o;
	met_pkg::res_t r0, r1;
	logic [1:0] n;

	function automatic st_t st_clear();
		st_t s;
		s.phase  = met_pkg::PH_IDLE;
		s.arg    = met_pkg::ARG_NONE;
		s.kind   = '0;
		s.letter = '0;
		s.err    = met_pkg::ERR_NONE;
		return s;
	endfunction

	function automatic st_t idle_next(st_t s, logic [7:0] c);
		st_t o;
		o = s;
		o.phase = met_pkg::PH_IDLE;
		if (c == met_pkg::CH_NUL) begin
			o = st_clear();
		end else if (c == met_pkg::CH_DOLLAR || c == met_pkg::CH_PCT) begin
			o.phase = (c == met_pkg::CH_DOLLAR) ? met_pkg::PH_DOL : met_pkg::PH_PCT;
			o.arg   = met_pkg::ARG_NONE;
		end
		return o;
	endfunction

	function automatic st_t dollar_next(st_t s, logic [7:0] c, logic [4:0] k);
		st_t o;
		o = s;
		if (k == met_pkg::KIND_ICON || k == met_pkg::KIND_TEXTW) begin
			o.kind   = k;
			o.letter = c;
			o.phase  = met_pkg::PH_WSEL;
		end else begin
			if (k == met_pkg::KIND_UNKNOWN && s.err == met_pkg::ERR_NONE)
				o.err = met_pkg::ERR_UNKNOWN;
			o.phase = (k == met_pkg::KIND_FONT) ? met_pkg::PH_FONTF : met_pkg::PH_IDLE;
		end
		return o;
	endfunction

	function automatic met_pkg::res_t end_rec(met_pkg::err_t e);
		return met_pkg::mk_rec(met_pkg::REC_END, '0, met_pkg::ARG_NONE, '0, '0, e);
	endfunction

	assign is_nul   = code == met_pkg::CH_NUL;
	assign is_digit = code >= met_pkg::CH_ZERO && code <= met_pkg::CH_NINE;
	assign kind_c   = met_pkg::classify(code);
	assign sel_c    = met_pkg::is_selector(code);

	// Byte handled as if no escape were open
	always_comb begin
		idle_o.emit = 1'b1;
		if (is_nul) begin
			idle_o.rec = end_rec(st_q.err);
		end else begin
			idle_o.rec = met_pkg::mk_rec(met_pkg::REC_TEXT, '0, met_pkg::ARG_NONE, '0,
				code, met_pkg::ERR_NONE);
			if (code == met_pkg::CH_DOLLAR || code == met_pkg::CH_PCT)
				idle_o.emit = 1'b0;
		end
	end

	// Next state
	always_comb begin
		st_nx = st_q;
		unique case (st_q.phase)
			met_pkg::PH_DOL, met_pkg::PH_PCT: begin
				if (is_nul) begin
					st_nx = st_clear();
				end else if (is_digit) begin
					st_nx.arg   = 5'(code - met_pkg::CH_ZERO);
					st_nx.phase = (st_q.phase == met_pkg::PH_DOL) ? met_pkg::PH_DOLD
						: met_pkg::PH_PCTD;
				end else if (st_q.phase == met_pkg::PH_DOL) begin
					st_nx = dollar_next(st_q, code, kind_c);
				end else begin
					st_nx.phase = met_pkg::PH_IDLE;
				end
			end
			met_pkg::PH_DOLD: begin
				if (is_nul) st_nx = st_clear();
				else st_nx = dollar_next(st_q, code, kind_c);
			end
			met_pkg::PH_PCTD: begin
				if (is_nul) st_nx = st_clear();
				else st_nx.phase = met_pkg::PH_IDLE;
			end
			met_pkg::PH_WSEL, met_pkg::PH_WBR: begin
				if (st_q.phase == met_pkg::PH_WSEL && sel_c) begin
					st_nx.letter = code;
					st_nx.phase  = met_pkg::PH_WBR;
				end else if (code == met_pkg::CH_LBR) begin
					st_nx.phase = met_pkg::PH_LABEL;
				end else begin
					st_nx = idle_next(st_q, code);
				end
			end
			met_pkg::PH_LABEL: begin
				if (code == met_pkg::CH_RBR) st_nx.phase = met_pkg::PH_IDLE;
				else if (is_nul) st_nx = st_clear();
			end
			met_pkg::PH_FONTF: begin
				if (code == met_pkg::CH_F) st_nx.phase = met_pkg::PH_IDLE;
				else st_nx = idle_next(st_q, code);
			end
			default: st_nx = idle_next(st_q, code);
		endcase
	end

	// Records
	always_comb begin
		n  = 2'd0;
		r0 = end_rec(met_pkg::ERR_NONE);
		r1 = end_rec(met_pkg::ERR_NONE);
		unique case (st_q.phase)
			met_pkg::PH_DOL, met_pkg::PH_PCT, met_pkg::PH_DOLD, met_pkg::PH_PCTD: begin
				if (is_nul) begin
					n  = 2'd1;
					r0 = end_rec(st_q.err);
				end else if (is_digit && (st_q.phase == met_pkg::PH_DOL ||
						st_q.phase == met_pkg::PH_PCT)) begin
					n = 2'd0;
				end else if (st_q.phase == met_pkg::PH_DOL || st_q.phase == met_pkg::PH_DOLD)
						begin
					if (kind_c != met_pkg::KIND_ICON && kind_c != met_pkg::KIND_TEXTW) begin
						n  = 2'd1;
						r0 = met_pkg::mk_rec(met_pkg::REC_TOKEN, kind_c, st_q.arg, code, '0,
							met_pkg::ERR_NONE);
					end
				end else begin
					n  = 2'd1;
					r0 = met_pkg::mk_rec(met_pkg::REC_TOKEN, met_pkg::KIND_PERCENT, st_q.arg,
						code, '0, met_pkg::ERR_NONE);
				end
			end
			met_pkg::PH_WSEL, met_pkg::PH_WBR: begin
				if (st_q.phase == met_pkg::PH_WSEL && sel_c) begin
					n = 2'd0;
				end else if (code == met_pkg::CH_LBR) begin
					n  = 2'd1;
					r0 = met_pkg::mk_rec(met_pkg::REC_HEADER, st_q.kind, st_q.arg,
						st_q.letter, '0, met_pkg::ERR_NONE);
				end else begin
					r0 = met_pkg::mk_rec(met_pkg::REC_TOKEN, st_q.kind, st_q.arg,
						st_q.letter, '0, met_pkg::ERR_NONE);
					r1 = idle_o.rec;
					n  = idle_o.emit ? 2'd2 : 2'd1;
				end
			end
			met_pkg::PH_LABEL: begin
				if (code == met_pkg::CH_RBR) begin
					n  = 2'd1;
					r0 = met_pkg::mk_rec(met_pkg::REC_CLOSE, '0, met_pkg::ARG_NONE, '0, '0,
						met_pkg::ERR_NONE);
				end else if (is_nul) begin
					n  = 2'd2;
					r0 = met_pkg::mk_rec(met_pkg::REC_MISSING, '0, met_pkg::ARG_NONE, '0, '0,
						met_pkg::ERR_NONE);
					r1 = end_rec((st_q.err == met_pkg::ERR_NONE) ? met_pkg::ERR_BRACKET
						: st_q.err);
				end else begin
					n  = 2'd1;
					r0 = met_pkg::mk_rec(met_pkg::REC_LABEL, '0, met_pkg::ARG_NONE, '0, code,
						met_pkg::ERR_NONE);
				end
			end
			met_pkg::PH_FONTF: begin
				if (code != met_pkg::CH_F) begin
					n  = idle_o.emit ? 2'd1 : 2'd0;
					r0 = idle_o.rec;
				end
			end
			default: begin
				n  = idle_o.emit ? 2'd1 : 2'd0;
				r0 = idle_o.rec;
			end
		endcase
		// mark the final record of this byte
		r0.last = (n == 2'd1);
		r1.last = (n == 2'd2);
	end

	assign step.n  = n;
	assign step.r0 = r0;
	assign step.r1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= st_clear();
		end else if (fire) begin
			st_q <= st_nx;
		end
	end

endmodule

/* rtl/core/met_outq.sv */
module met_outq #(
	parameter int unsigned DEPTH = met_pkg::MET_QDEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  met_pkg::step_out_t wr,
	input  logic               rd_en,
	output met_pkg::res_t      head,
	output logic               head_valid,
	output met_pkg::q_stat_t   stat
);

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	met_pkg::res_t mem [DEPTH];
	logic [IW-1:0] wr_q, rd_q, wr1;
	logic [CW-1:0] cnt_q;
	logic [1:0]    n_push;
	logic          pop;

	function automatic logic [IW-1:0] ptr_inc(logic [IW-1:0] p);
		return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign n_push     = wr_en ? wr.n : 2'd0;
	assign wr1        = ptr_inc(wr_q);
	assign pop        = rd_en && (cnt_q != '0);
	assign head       = mem[rd_q];
	assign head_valid = cnt_q != '0;
	assign stat.room  = cnt_q <= CW'(DEPTH - 2);
	assign stat.full  = cnt_q == CW'(DEPTH);

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) mem[wr_q] <= wr.r0;
		if (n_push == 2'd2) mem[wr1]  <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (n_push == 2'd1) wr_q <= wr1;
			else if (n_push == 2'd2) wr_q <= ptr_inc(wr1);
			if (pop) rd_q <= ptr_inc(rd_q);
			cnt_q <= cnt_q + CW'(n_push) - CW'(pop);
		end
	end

endmodule

/* rtl/core/markup_escape_tokenizer.sv */
// Channel  Dir  Handshake                   Payload
// s_*      in   s_tvalid / s_tready         s_tdata[7:0] = code
// m_*      out  m_tvalid / m_tready         m_tdata[31:0] record, m_tlast = last
//
// Path: a byte accepted into the input register is parsed there, and its records are
// written into the output queue when the parse fires; the first then shows on m_*.
// Throughput: one byte per cycle while each byte yields at most one record and m_tready
// stays high; the output port moves one record per cycle while m_tready is high.
// Reset clears the parser state and the queue pointers; no clearing pass.
// Stalls: the input register holds its byte while the queue has fewer than two
// free slots, and s_tready drops only then.
module markup_escape_tokenizer #(
	parameter int unsigned QDEPTH = met_pkg::MET_QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] code
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] record_type, [7:3] kind, [12:8] arg, [20:13] letter,
	// [28:21] data_byte, [30:29] error_code, [31] zero
	output logic [31:0] m_tdata,
	output logic        m_tlast
);

	logic               valid_s1;
	logic [7:0]         code_s1;
	logic               fire;
	met_pkg::step_out_t step;
	met_pkg::res_t      head;
	met_pkg::q_stat_t   q_stat;

	// Parse the held byte once the queue can absorb two records
	assign fire     = valid_s1 && q_stat.room;
	assign s_tready = !valid_s1 || fire;

	// Input register: load a new request whenever it is empty or the held byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) code_s1 <= s_tdata;
	end

	// Escape parser: phase and held token fields advance on each parsed byte
	met_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.code   (code_s1),
		.step   (step)
	);

	// Result queue: accept up to two records, drain one per cycle while m_tready is high
	met_outq #(
		.DEPTH (QDEPTH)
	) u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (fire),
		.wr         (step),
		.rd_en      (m_tready),
		.head       (head),
		.head_valid (m_tvalid),
		.stat       (q_stat)
	);

	assign m_tdata = {1'b0, head.error_code, head.data_byte, head.letter, head.arg,
		head.kind, head.rec_type};
	assign m_tlast = head.last;

`ifndef SYNTHESIS
	// A stalled byte stays in the input register unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> valid_s1 && $stable(code_s1))
		else $error("held byte lost while stalled");

	// A terminator always produces the end-of-string record
	a_term: assert property (@(posedge clk) disable iff (!arst_n)
		fire && code_s1 == met_pkg::CH_NUL |->
		(step.n == 2'd1 && step.r0.rec_type == met_pkg::REC_END) ||
		(step.n == 2'd2 && step.r1.rec_type == met_pkg::REC_END))
		else $error("terminator without end record");

	// Only the final record of a pair carries last
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		step.n == 2'd2 |-> step.r1.last && !step.r0.last)
		else $error("last flag misplaced");

	// Queue never accepts a parse while full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !fire)
		else $error("parse into full queue");
`endif

endmodule
